@@ design/mfep_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mfep_pkg: shared types and constants of the MIDI file event parser.
// Holds the parser phase, result kinds, error codes and the result record.
// -----------------------------------------------------------------------------
package mfep_pkg;

    typedef enum logic [4:0] {
        PH_HMAGIC, PH_HSKIP, PH_HFMT, PH_HTRK, PH_HDIV, PH_TMAGIC, PH_TLEN,
        PH_DELTA, PH_STATUS, PH_NOTE, PH_DISCARD, PH_MTYPE, PH_MLEN, PH_TEMPO,
        PH_SKIP, PH_SYSEX, PH_DONE
    } phase_t;

    localparam logic [2:0] K_NOTE_ON   = 3'd0;
    localparam logic [2:0] K_NOTE_OFF  = 3'd1;
    localparam logic [2:0] K_TIME      = 3'd2;
    localparam logic [2:0] K_TEMPO     = 3'd3;
    localparam logic [2:0] K_HEADER    = 3'd4;
    localparam logic [2:0] K_TRACK_END = 3'd5;
    localparam logic [2:0] K_FILE_END  = 3'd6;
    localparam logic [2:0] K_ERROR     = 3'd7;

    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_HDR_MAGIC = 3'd1;
    localparam logic [2:0] E_TRK_MAGIC = 3'd2;
    localparam logic [2:0] E_TEMPO_LEN = 3'd3;
    localparam logic [2:0] E_STATUS    = 3'd4;
    localparam logic [2:0] E_VLQ_LONG  = 3'd5;

    localparam logic [7:0] META_EOT   = 8'h2F;
    localparam logic [7:0] META_TEMPO = 8'h51;

    // One result word; tdata packs these fields high to low, so kind is lowest.
    typedef struct packed {
        logic [2:0]  error_code;
        logic [15:0] trk_total;
        logic [7:0]  format;
        logic [31:0] value;
        logic [7:0]  offset;
        logic [2:0]  kind;
    } result_t;

    localparam int RES_W = 70;
    localparam int OUT_W = 72;

    function automatic logic [7:0] hdr_magic(input logic [1:0] i);
        case (i)
            2'd0: hdr_magic = 8'h4D;
            2'd1: hdr_magic = 8'h54;
            2'd2: hdr_magic = 8'h68;
            default: hdr_magic = 8'h64;
        endcase
    endfunction

    function automatic logic [7:0] trk_magic(input logic [1:0] i);
        case (i)
            2'd0: trk_magic = 8'h4D;
            2'd1: trk_magic = 8'h54;
            2'd2: trk_magic = 8'h72;
            default: trk_magic = 8'h6B;
        endcase
    endfunction

endpackage

@@ design/mfep_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mfep_core: per-byte parser state update.
// Takes one registered byte, updates parser state, produces up to 2 results.
// -----------------------------------------------------------------------------
module mfep_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                first_of_file,
    output logic [1:0]          res_count,
    output mfep_pkg::result_t   res0,
    output mfep_pkg::result_t   res1,
    output mfep_pkg::result_t   res2
);

    mfep_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [27:0] vlq_reg, vlq_next;
    logic [2:0]  vlqn_reg, vlqn_next;
    logic [27:0] held_reg, held_next;
    logic [7:0]  evk_reg, evk_next;
    logic [27:0] skip_reg, skip_next;
    logic [23:0] acc_reg, acc_next;
    logic [31:0] ticks_reg, ticks_next;
    logic [31:0] longest_reg, longest_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  fmt_reg, fmt_next;
    logic        err_reg, err_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mfep_pkg::PH_HMAGIC;
            idx_reg <= '0; vlq_reg <= '0; vlqn_reg <= '0; held_reg <= '0;
            evk_reg <= '0; skip_reg <= '0; acc_reg <= '0; ticks_reg <= '0;
            longest_reg <= '0; left_reg <= '0; fmt_reg <= '0; err_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg <= idx_next; vlq_reg <= vlq_next; vlqn_reg <= vlqn_next;
            held_reg <= held_next; evk_reg <= evk_next; skip_reg <= skip_next;
            acc_reg <= acc_next; ticks_reg <= ticks_next;
            longest_reg <= longest_next; left_reg <= left_next;
            fmt_reg <= fmt_next; err_reg <= err_next;
        end
    end

    // Next state and results for one byte.
    always_comb
    begin
        mfep_pkg::phase_t ph;
        logic [2:0]  ix;
        logic [27:0] vq;
        logic [2:0]  vn;
        logic [27:0] hd;
        logic [7:0]  ek;
        logic [27:0] sk;
        logic [23:0] ac;
        logic [31:0] tk;
        logic [31:0] lg;
        logic [15:0] lf;
        logic [7:0]  fm;
        logic        er;
        logic [1:0]  n;
        mfep_pkg::result_t r [3];
        logic [27:0] vq_new;
        logic [2:0]  vn_new;
        logic [32:0] sum;
        logic [3:0]  hi;
        logic [15:0] lf_dec;
        logic [23:0] ac_sh;

        ph = phase_reg; ix = idx_reg; vq = vlq_reg; vn = vlqn_reg; hd = held_reg;
        ek = evk_reg; sk = skip_reg; ac = acc_reg; tk = ticks_reg;
        lg = longest_reg; lf = left_reg; fm = fmt_reg; er = err_reg;
        if (first_of_file)
        begin
            ph = mfep_pkg::PH_HMAGIC; ix = '0; vq = '0; vn = '0; hd = '0; ek = '0;
            sk = '0; ac = '0; tk = '0; lg = '0; lf = '0; fm = '0; er = 1'b0;
        end
        n = 2'd0;
        r[0] = '0; r[1] = '0; r[2] = '0;
        vq_new = {vq[20:0], data_byte[6:0]};
        vn_new = vn + 3'd1;
        hi = data_byte[7:4];
        ac_sh = {ac[15:0], data_byte};
        sum = {1'b0, tk} + {5'd0, vq_new};
        lf_dec = lf - 16'd1;

        if (!er)
        begin
            case (ph)
                mfep_pkg::PH_HMAGIC:
                    if (data_byte != mfep_pkg::hdr_magic(ix[1:0]))
                    begin
                        r[0].kind = mfep_pkg::K_ERROR; r[0].error_code = mfep_pkg::E_HDR_MAGIC;
                        n = 2'd1; er = 1'b1; ph = mfep_pkg::PH_DONE;
                    end
                    else if (ix == 3'd3)
                    begin
                        ix = '0; ph = mfep_pkg::PH_HSKIP;
                    end
                    else ix = ix + 3'd1;
                mfep_pkg::PH_HSKIP:
                    if (ix == 3'd4)
                    begin
                        ix = '0; ph = mfep_pkg::PH_HFMT;
                    end
                    else ix = ix + 3'd1;
                mfep_pkg::PH_HFMT:
                begin
                    fm = data_byte; ix = '0; ac = '0; ph = mfep_pkg::PH_HTRK;
                end
                mfep_pkg::PH_HTRK:
                    if (ix == 3'd1)
                    begin
                        lf = ac_sh[15:0]; ac = '0; ix = '0; ph = mfep_pkg::PH_HDIV;
                    end
                    else
                    begin
                        ac = ac_sh; ix = ix + 3'd1;
                    end
                mfep_pkg::PH_HDIV:
                    if (ix == 3'd1)
                    begin
                        r[0].kind = mfep_pkg::K_HEADER; r[0].value = {16'd0, ac_sh[15:0]};
                        r[0].format = fm; r[0].trk_total = lf; n = 2'd1;
                        ac = '0; ix = '0;
                        if (lf == 16'd0)
                        begin
                            r[1].kind = mfep_pkg::K_FILE_END; r[1].value = lg;
                            n = 2'd2; ph = mfep_pkg::PH_DONE;
                        end
                        else ph = mfep_pkg::PH_TMAGIC;
                    end
                    else
                    begin
                        ac = ac_sh; ix = ix + 3'd1;
                    end
                mfep_pkg::PH_TMAGIC:
                    if (data_byte != mfep_pkg::trk_magic(ix[1:0]))
                    begin
                        r[0].kind = mfep_pkg::K_ERROR; r[0].error_code = mfep_pkg::E_TRK_MAGIC;
                        n = 2'd1; er = 1'b1; ph = mfep_pkg::PH_DONE;
                    end
                    else if (ix == 3'd3)
                    begin
                        ix = '0; ph = mfep_pkg::PH_TLEN;
                    end
                    else ix = ix + 3'd1;
                mfep_pkg::PH_TLEN:
                    if (ix == 3'd3)
                    begin
                        ix = '0; tk = '0; vq = '0; vn = '0; ph = mfep_pkg::PH_DELTA;
                    end
                    else ix = ix + 3'd1;
                mfep_pkg::PH_DELTA:
                begin
                    vq = vq_new;
                    if (data_byte[7])
                    begin
                        vn = vn_new;
                        if (vn_new >= 3'd4)
                        begin
                            r[0].kind = mfep_pkg::K_ERROR; r[0].error_code = mfep_pkg::E_VLQ_LONG;
                            n = 2'd1; er = 1'b1; ph = mfep_pkg::PH_DONE;
                        end
                    end
                    else
                    begin
                        hd = vq_new;
                        tk = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        vq = '0; vn = '0; ph = mfep_pkg::PH_STATUS;
                    end
                end
                mfep_pkg::PH_STATUS:
                    if (data_byte == 8'hFF) ph = mfep_pkg::PH_MTYPE;
                    else if (data_byte == 8'hF0 || data_byte == 8'hF7)
                        ph = mfep_pkg::PH_SYSEX;
                    else
                    begin
                        if (hd > 28'd255)
                        begin
                            r[0].kind = mfep_pkg::K_TIME; r[0].value = {4'd0, hd};
                            n = 2'd1; hd = '0;
                        end
                        if (hi == 4'h8 || hi == 4'h9)
                        begin
                            ek = data_byte; ix = '0; ph = mfep_pkg::PH_NOTE;
                        end
                        else if (hi >= 4'hA && hi <= 4'hE)
                        begin
                            if (hd != '0)
                            begin
                                r[n].kind = mfep_pkg::K_TIME; r[n].value = {4'd0, hd};
                                n = n + 2'd1; hd = '0;
                            end
                            sk = (hi == 4'hC || hi == 4'hD) ? 28'd1 : 28'd2;
                            ph = mfep_pkg::PH_DISCARD;
                        end
                        else
                        begin
                            r[n].kind = mfep_pkg::K_ERROR; r[n].error_code = mfep_pkg::E_STATUS;
                            n = n + 2'd1; er = 1'b1; ph = mfep_pkg::PH_DONE;
                        end
                    end
                mfep_pkg::PH_NOTE:
                    if (ix == 3'd0)
                    begin
                        ac = {16'd0, data_byte}; ix = 3'd1;
                    end
                    else
                    begin
                        r[0].kind = (ek[7:4] == 4'h9 && data_byte != 8'd0) ?
                                    mfep_pkg::K_NOTE_ON : mfep_pkg::K_NOTE_OFF;
                        r[0].offset = hd[7:0];
                        r[0].value = {16'd0, ac[7:0], data_byte};
                        n = 2'd1; ix = '0; vq = '0; vn = '0; ph = mfep_pkg::PH_DELTA;
                    end
                mfep_pkg::PH_DISCARD, mfep_pkg::PH_SKIP:
                begin
                    if (sk != '0) sk = sk - 28'd1;
                    if (sk == '0)
                    begin
                        vq = '0; vn = '0; ph = mfep_pkg::PH_DELTA;
                    end
                end
                mfep_pkg::PH_MTYPE:
                begin
                    ek = data_byte; vq = '0; vn = '0; ph = mfep_pkg::PH_MLEN;
                end
                mfep_pkg::PH_MLEN:
                begin
                    vq = vq_new;
                    if (data_byte[7])
                    begin
                        vn = vn_new;
                        if (vn_new >= 3'd4)
                        begin
                            r[0].kind = mfep_pkg::K_ERROR; r[0].error_code = mfep_pkg::E_VLQ_LONG;
                            n = 2'd1; er = 1'b1; ph = mfep_pkg::PH_DONE;
                        end
                    end
                    else
                    begin
                        vq = '0; vn = '0;
                        if (ek == mfep_pkg::META_EOT)
                        begin
                            r[0].kind = mfep_pkg::K_TRACK_END; r[0].value = tk; n = 2'd1;
                            if (tk > lg) lg = tk;
                            lf = lf_dec;
                            if (lf_dec == 16'd0)
                            begin
                                r[1].kind = mfep_pkg::K_FILE_END; r[1].value = lg;
                                n = 2'd2; ph = mfep_pkg::PH_DONE;
                            end
                            else
                            begin
                                ph = mfep_pkg::PH_TMAGIC; ix = '0;
                            end
                        end
                        else if (ek == mfep_pkg::META_TEMPO)
                        begin
                            if (vq_new != 28'd3)
                            begin
                                r[0].kind = mfep_pkg::K_ERROR;
                                r[0].error_code = mfep_pkg::E_TEMPO_LEN;
                                n = 2'd1; er = 1'b1; ph = mfep_pkg::PH_DONE;
                            end
                            else
                            begin
                                ac = '0; ix = '0; ph = mfep_pkg::PH_TEMPO;
                            end
                        end
                        else if (vq_new == '0) ph = mfep_pkg::PH_DELTA;
                        else
                        begin
                            sk = vq_new; ph = mfep_pkg::PH_SKIP;
                        end
                    end
                end
                mfep_pkg::PH_TEMPO:
                    if (ix == 3'd2)
                    begin
                        r[0].kind = mfep_pkg::K_TEMPO; r[0].value = {8'd0, ac_sh};
                        n = 2'd1; ac = ac_sh; ix = '0; vq = '0; vn = '0;
                        ph = mfep_pkg::PH_DELTA;
                    end
                    else
                    begin
                        ac = ac_sh; ix = ix + 3'd1;
                    end
                mfep_pkg::PH_SYSEX:
                    if (data_byte == 8'hF7)
                    begin
                        vq = '0; vn = '0; ph = mfep_pkg::PH_DELTA;
                    end
                default: ;
            endcase
        end

        phase_next = ph; idx_next = ix; vlq_next = vq; vlqn_next = vn; held_next = hd;
        evk_next = ek; skip_next = sk; acc_next = ac; ticks_next = tk;
        longest_next = lg; left_next = lf; fmt_next = fm; err_next = er;
        res_count = n; res0 = r[0]; res1 = r[1]; res2 = r[2];
    end

endmodule

@@ design/mfep_out_queue.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mfep_out_queue: result buffer feeding the output stream.
// Holds up to four result words in a small ring; releases one per cycle while out_ready is high.
// -----------------------------------------------------------------------------
module mfep_out_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [1:0]        push_count,
    input  mfep_pkg::result_t in0,
    input  mfep_pkg::result_t in1,
    input  mfep_pkg::result_t in2,
    output logic [2:0]        free_slots,
    output logic              out_valid,
    input  logic              out_ready,
    output mfep_pkg::result_t out_res,
    output logic              out_last
);

    mfep_pkg::result_t slot_reg [4];
    logic [3:0] last_reg;
    logic [1:0] rd_reg, rd_next;
    logic [1:0] wr_reg, wr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [2:0] added;

    assign pop        = out_valid && out_ready;
    assign added      = push ? {1'b0, push_count} : 3'd0;
    assign out_valid  = cnt_reg != 3'd0;
    assign out_res    = slot_reg[rd_reg];
    assign out_last   = last_reg[rd_reg];
    assign free_slots = 3'd4 - cnt_reg;
    assign rd_next    = rd_reg + {1'b0, pop};
    assign wr_next    = wr_reg + added[1:0];
    assign cnt_next   = cnt_reg + added - {2'd0, pop};

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0; wr_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_next; wr_reg <= wr_next; cnt_reg <= cnt_next;
        end
    end

    // Write the burst of results; the last of the burst carries last.
    always_ff @(posedge clk)
    begin
        if (push && push_count != 2'd0)
        begin
            slot_reg[wr_reg] <= in0;
            last_reg[wr_reg] <= (push_count == 2'd1);
            if (push_count >= 2'd2)
            begin
                slot_reg[wr_reg + 2'd1] <= in1;
                last_reg[wr_reg + 2'd1] <= (push_count == 2'd2);
            end
            if (push_count == 2'd3)
            begin
                slot_reg[wr_reg + 2'd2] <= in2;
                last_reg[wr_reg + 2'd2] <= 1'b1;
            end
        end
    end

endmodule

@@ design/midi_file_event_parser.sv @@
`timescale 1ns / 1ps
// Flow: a byte is registered at the input, the parser steps on it once the
// result buffer has room, and its result words are offered from that buffer.
// Throughput: one byte per cycle while at most one word waits in the four-word
// result buffer; the input stalls while two or more words wait there.
// Reset: rst_n clears parser state and empties the input register and the
// result buffer; first_of_file restarts parsing at that byte.
// -----------------------------------------------------------------------------
// midi_file_event_parser: Standard MIDI File byte stream to event words.
// Input register, per-byte parser update, and a result buffer.
// -----------------------------------------------------------------------------
module midi_file_event_parser
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,  // data_byte
    input  logic                      s_tuser,  // first_of_file
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [mfep_pkg::OUT_W-1:0] m_tdata, // kind, offset, value, format,
                                               // trk_total, error_code, zero pad
    output logic                      m_tlast
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic [1:0] res_count;
    logic [2:0] free_slots;
    logic       step;
    mfep_pkg::result_t res0, res1, res2, out_res;

    // Parser step fires when the buffer can take a worst-case burst.
    assign step     = in_valid_reg && (free_slots >= 3'd3);
    assign s_tready = !in_valid_reg || step;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    mfep_core u_core
    (
        .clk(clk), .rst_n(rst_n), .step(step), .data_byte(in_byte_reg),
        .first_of_file(in_first_reg), .res_count(res_count),
        .res0(res0), .res1(res1), .res2(res2)
    );

    mfep_out_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .push(step), .push_count(res_count),
        .in0(res0), .in1(res1), .in2(res2), .free_slots(free_slots),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(out_res),
        .out_last(m_tlast)
    );

    assign m_tdata = {{(mfep_pkg::OUT_W - mfep_pkg::RES_W){1'b0}}, out_res};

`ifndef SYNTHESIS
    // A parser step never overruns the result buffer.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> free_slots >= {1'b0, res_count})
        else $error("result buffer overrun");
    // An input word waiting in the register is taken only by a parser step.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending input word lost");
    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word changed while stalled");
`endif

endmodule

@@ dv/tb_midi_file_event_parser.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_midi_file_event_parser: self-checking bench for the MIDI file parser.
// Feeds whole and broken MIDI files byte by byte, predicts every result word
// with an internal parser model, and compares each word as it leaves the block.
// -----------------------------------------------------------------------------
module tb_midi_file_event_parser;

    // Expected result word with its last flag.
    typedef struct {
        mfep_pkg::result_t res;
        logic              last;
    } event_word_t;

    // Parser model plus the queue of predicted words.
    class event_scoreboard;
        event_word_t       pending[$];
        int                mismatches;
        mfep_pkg::phase_t  ph;
        int unsigned       idx;
        logic [27:0]       vacc;
        int unsigned       vcnt;
        logic [27:0]       delta;
        logic [7:0]        held_kind;
        logic [27:0]       skip_cnt;
        logic [23:0]       acc;
        logic [31:0]       ticks;
        logic [31:0]       longest;
        logic [15:0]       tracks_left;
        logic [7:0]        fmt;
        logic              err;
        mfep_pkg::result_t burst[$];

        function void restart();
            ph = mfep_pkg::PH_HMAGIC; idx = 0; vacc = '0; vcnt = 0; delta = '0;
            held_kind = '0; skip_cnt = '0; acc = '0; ticks = '0; longest = '0;
            tracks_left = '0; fmt = '0; err = 1'b0;
        endfunction

        function void emit(logic [2:0] k, logic [7:0] o, logic [31:0] v,
                           logic [7:0] f, logic [15:0] tc, logic [2:0] e);
            mfep_pkg::result_t r;
            r.kind = k; r.offset = o; r.value = v; r.format = f;
            r.trk_total = tc; r.error_code = e;
            burst.push_back(r);
        endfunction

        function void raise_error(logic [2:0] code);
            err = 1'b1;
            ph = mfep_pkg::PH_DONE;
            emit(mfep_pkg::K_ERROR, 8'd0, 32'd0, 8'd0, 16'd0, code);
        endfunction

        // Returns 0 while more bytes follow, 1 when done, 2 when too long.
        function int take_vlq(logic [7:0] b);
            vacc = {vacc[20:0], b[6:0]};
            vcnt++;
            if (b[7])
                return (vcnt >= 4) ? 2 : 0;
            vcnt = 0;
            return 1;
        endfunction

        function void close_track();
            emit(mfep_pkg::K_TRACK_END, 8'd0, ticks, 8'd0, 16'd0, mfep_pkg::E_NONE);
            if (ticks > longest)
                longest = ticks;
            tracks_left = tracks_left - 16'd1;
            if (tracks_left == 16'd0)
            begin
                emit(mfep_pkg::K_FILE_END, 8'd0, longest, 8'd0, 16'd0, mfep_pkg::E_NONE);
                ph = mfep_pkg::PH_DONE;
            end
            else
            begin
                ph = mfep_pkg::PH_TMAGIC;
                idx = 0;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic first);
            int          v;
            logic [7:0]  hi;
            logic [27:0] len;
            event_word_t w;
            burst.delete();
            if (first)
                restart();
            if (!err)
            begin
                case (ph)
                    mfep_pkg::PH_HMAGIC:
                    begin
                        if (b != mfep_pkg::hdr_magic(idx[1:0]))
                            raise_error(mfep_pkg::E_HDR_MAGIC);
                        else
                        begin
                            idx++;
                            if (idx >= 4)
                            begin
                                idx = 0; ph = mfep_pkg::PH_HSKIP;
                            end
                        end
                    end
                    mfep_pkg::PH_HSKIP:
                    begin
                        idx++;
                        if (idx >= 5)
                        begin
                            idx = 0; ph = mfep_pkg::PH_HFMT;
                        end
                    end
                    mfep_pkg::PH_HFMT:
                    begin
                        fmt = b; idx = 0; acc = '0; ph = mfep_pkg::PH_HTRK;
                    end
                    mfep_pkg::PH_HTRK, mfep_pkg::PH_HDIV:
                    begin
                        acc = {acc[15:0], b};
                        idx++;
                        if (idx >= 2)
                        begin
                            idx = 0;
                            if (ph == mfep_pkg::PH_HTRK)
                            begin
                                tracks_left = acc[15:0];
                                ph = mfep_pkg::PH_HDIV;
                            end
                            else
                            begin
                                emit(mfep_pkg::K_HEADER, 8'd0, {16'd0, acc[15:0]}, fmt,
                                     tracks_left, mfep_pkg::E_NONE);
                                if (tracks_left == 16'd0)
                                begin
                                    emit(mfep_pkg::K_FILE_END, 8'd0, longest, 8'd0, 16'd0,
                                         mfep_pkg::E_NONE);
                                    ph = mfep_pkg::PH_DONE;
                                end
                                else
                                    ph = mfep_pkg::PH_TMAGIC;
                            end
                            acc = '0;
                        end
                    end
                    mfep_pkg::PH_TMAGIC:
                    begin
                        if (b != mfep_pkg::trk_magic(idx[1:0]))
                            raise_error(mfep_pkg::E_TRK_MAGIC);
                        else
                        begin
                            idx++;
                            if (idx >= 4)
                            begin
                                idx = 0; ph = mfep_pkg::PH_TLEN;
                            end
                        end
                    end
                    mfep_pkg::PH_TLEN:
                    begin
                        idx++;
                        if (idx >= 4)
                        begin
                            idx = 0; ticks = '0; vacc = '0; vcnt = 0;
                            ph = mfep_pkg::PH_DELTA;
                        end
                    end
                    mfep_pkg::PH_DELTA:
                    begin
                        v = take_vlq(b);
                        if (v == 2)
                            raise_error(mfep_pkg::E_VLQ_LONG);
                        else if (v == 1)
                        begin
                            delta = vacc;
                            if (ticks > 32'hFFFF_FFFF - {4'd0, delta})
                                ticks = 32'hFFFF_FFFF;
                            else
                                ticks = ticks + {4'd0, delta};
                            vacc = '0; vcnt = 0;
                            ph = mfep_pkg::PH_STATUS;
                        end
                    end
                    mfep_pkg::PH_STATUS:
                    begin
                        hi = b & 8'hF0;
                        if (b == 8'hFF)
                            ph = mfep_pkg::PH_MTYPE;
                        else if (b == 8'hF0 || b == 8'hF7)
                            ph = mfep_pkg::PH_SYSEX;
                        else
                        begin
                            if (delta > 28'd255)
                            begin
                                emit(mfep_pkg::K_TIME, 8'd0, {4'd0, delta}, 8'd0, 16'd0,
                                     mfep_pkg::E_NONE);
                                delta = '0;
                            end
                            if (hi == 8'h80 || hi == 8'h90)
                            begin
                                held_kind = b; idx = 0; ph = mfep_pkg::PH_NOTE;
                            end
                            else if (hi inside {8'hA0, 8'hB0, 8'hC0, 8'hD0, 8'hE0})
                            begin
                                if (delta > 28'd0)
                                begin
                                    emit(mfep_pkg::K_TIME, 8'd0, {4'd0, delta}, 8'd0, 16'd0,
                                         mfep_pkg::E_NONE);
                                    delta = '0;
                                end
                                skip_cnt = (hi == 8'hC0 || hi == 8'hD0) ? 28'd1 : 28'd2;
                                ph = mfep_pkg::PH_DISCARD;
                            end
                            else
                                raise_error(mfep_pkg::E_STATUS);
                        end
                    end
                    mfep_pkg::PH_NOTE:
                    begin
                        if (idx == 0)
                        begin
                            acc = {16'd0, b}; idx = 1;
                        end
                        else
                        begin
                            emit((held_kind[7:4] == 4'h9 && b != 8'd0) ?
                                 mfep_pkg::K_NOTE_ON : mfep_pkg::K_NOTE_OFF,
                                 delta[7:0], {16'd0, acc[7:0], b}, 8'd0, 16'd0,
                                 mfep_pkg::E_NONE);
                            idx = 0; vacc = '0; vcnt = 0; ph = mfep_pkg::PH_DELTA;
                        end
                    end
                    mfep_pkg::PH_DISCARD, mfep_pkg::PH_SKIP:
                    begin
                        if (skip_cnt > 28'd0)
                            skip_cnt = skip_cnt - 28'd1;
                        if (skip_cnt == 28'd0)
                        begin
                            vacc = '0; vcnt = 0; ph = mfep_pkg::PH_DELTA;
                        end
                    end
                    mfep_pkg::PH_MTYPE:
                    begin
                        held_kind = b; vacc = '0; vcnt = 0; ph = mfep_pkg::PH_MLEN;
                    end
                    mfep_pkg::PH_MLEN:
                    begin
                        v = take_vlq(b);
                        if (v == 2)
                            raise_error(mfep_pkg::E_VLQ_LONG);
                        else if (v == 1)
                        begin
                            len = vacc;
                            vacc = '0; vcnt = 0;
                            if (held_kind == mfep_pkg::META_EOT)
                                close_track();
                            else if (held_kind == mfep_pkg::META_TEMPO)
                            begin
                                if (len != 28'd3)
                                    raise_error(mfep_pkg::E_TEMPO_LEN);
                                else
                                begin
                                    acc = '0; idx = 0; ph = mfep_pkg::PH_TEMPO;
                                end
                            end
                            else if (len == 28'd0)
                                ph = mfep_pkg::PH_DELTA;
                            else
                            begin
                                skip_cnt = len; ph = mfep_pkg::PH_SKIP;
                            end
                        end
                    end
                    mfep_pkg::PH_TEMPO:
                    begin
                        acc = {acc[15:0], b};
                        idx++;
                        if (idx >= 3)
                        begin
                            emit(mfep_pkg::K_TEMPO, 8'd0, {8'd0, acc}, 8'd0, 16'd0,
                                 mfep_pkg::E_NONE);
                            idx = 0; vacc = '0; vcnt = 0; ph = mfep_pkg::PH_DELTA;
                        end
                    end
                    mfep_pkg::PH_SYSEX:
                    begin
                        if (b == 8'hF7)
                        begin
                            vacc = '0; vcnt = 0; ph = mfep_pkg::PH_DELTA;
                        end
                    end
                    default: ;
                endcase
            end
            foreach (burst[i])
            begin
                w.res = burst[i];
                w.last = (i == burst.size() - 1);
                pending.push_back(w);
            end
        endfunction

        function void check_word(mfep_pkg::result_t got, logic got_last);
            event_word_t w;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word kind=%0d value=%h", got.kind, got.value);
                return;
            end
            w = pending.pop_front();
            if (got !== w.res || got_last !== w.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("word mismatch: exp k=%0d o=%h v=%h f=%h t=%h e=%0d l=%b",
                             w.res.kind, w.res.offset, w.res.value, w.res.format,
                             w.res.trk_total, w.res.error_code, w.last);
                    $display("               got k=%0d o=%h v=%h f=%h t=%h e=%0d l=%b",
                             got.kind, got.offset, got.value, got.format,
                             got.trk_total, got.error_code, got_last);
                end
            end
        endfunction
    endclass

    logic                       clk = 0;
    logic                       rst_n = 0;
    logic                       s_tvalid = 0;
    logic                       s_tready;
    logic [7:0]                 s_tdata = 0;
    logic                       s_tuser = 0;
    logic                       m_tvalid;
    logic                       m_tready = 0;
    logic [mfep_pkg::OUT_W-1:0] m_tdata;
    logic                       m_tlast;

    event_scoreboard   board;
    logic [7:0]        file_bytes[$];
    logic              file_first[$];
    int                byte_total;
    int                cycle_count;
    bit                hold_off;

    always #10 clk = ~clk;

    midi_file_event_parser dut (.*);

    // Gap length: mostly short, sometimes long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sends one byte, with a random lead-in gap when gaps is set.
    task automatic send_byte(logic [7:0] b, logic first, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        repeat (g)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_byte(b, first);
        byte_total++;
    endtask

    task automatic push(logic [7:0] b);
        file_bytes.push_back(b);
        file_first.push_back(1'b0);
    endtask

    task automatic push_vlq(logic [27:0] v);
        if (v >= 28'h200000)
            push(8'h80 | {1'b0, v[27:21]});
        if (v >= 28'h4000)
            push(8'h80 | {1'b0, v[20:14]});
        if (v >= 28'h80)
            push(8'h80 | {1'b0, v[13:7]});
        push({1'b0, v[6:0]});
    endtask

    task automatic push_header(logic [7:0] f, logic [15:0] tracks, logic [15:0] div);
        push("M"); push("T"); push("h"); push("d");
        file_first[file_first.size() - 4] = 1'b1;
        push(8'd0); push(8'd0); push(8'd0); push(8'd6); push(8'd0);
        push(f); push(tracks[15:8]); push(tracks[7:0]); push(div[15:8]); push(div[7:0]);
    endtask

    task automatic push_track_head();
        push("M"); push("T"); push("r"); push("k");
        repeat (4)
            push(8'($urandom_range(0, 255)));
    endtask

    // Random delta, mostly short with some long values.
    function automatic logic [27:0] rand_delta();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 28'($urandom_range(0, 127));
        if (r < 8)
            return 28'($urandom_range(0, 255));
        if (r < 9)
            return 28'($urandom_range(256, 20000));
        return 28'($urandom);
    endfunction

    // One random event after its delta; broken events now and then when noisy.
    task automatic push_event(bit noisy);
        int r;
        int n;
        push_vlq(rand_delta());
        r = $urandom_range(0, 15);
        if (noisy && $urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 3))
                0: push(8'($urandom_range(0, 127)));
                1: push(8'(8'hF1 + $urandom_range(0, 5)));
                2:
                begin
                    push(8'hFF); push(mfep_pkg::META_TEMPO);
                    push(8'($urandom_range(4, 9)));
                end
                default:
                begin
                    push(8'h81); push(8'h82); push(8'h83); push(8'h84);
                end
            endcase
            return;
        end
        if (r < 8)
        begin
            push(($urandom_range(0, 1) ? 8'h90 : 8'h80) | 8'($urandom_range(0, 15)));
            push(8'($urandom_range(0, 255)));
            push($urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(0, 255)));
        end
        else if (r < 11)
        begin
            push(8'(8'hA0 + 8'h10 * $urandom_range(0, 4) + $urandom_range(0, 15)));
            push(8'($urandom_range(0, 127)));
            push(8'($urandom_range(0, 127)));
        end
        else if (r < 12)
        begin
            push($urandom_range(0, 1) ? 8'hF0 : 8'hF7);
            repeat ($urandom_range(0, 4))
                push(8'($urandom_range(0, 246)));
            push(8'hF7);
        end
        else if (r < 14)
        begin
            push(8'hFF); push(mfep_pkg::META_TEMPO); push(8'd3);
            repeat (3)
                push(8'($urandom_range(0, 255)));
        end
        else
        begin
            push(8'hFF);
            push($urandom_range(0, 1) ? 8'h01 : 8'($urandom_range(0, 255)));
            if (file_bytes[file_bytes.size() - 1] inside {mfep_pkg::META_EOT,
                                                          mfep_pkg::META_TEMPO})
                file_bytes[file_bytes.size() - 1] = 8'h03;
            n = $urandom_range(0, 5);
            push(8'(n));
            repeat (n)
                push(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic push_file(int tracks, int events, bit noisy);
        push_header(8'($urandom_range(0, 255)), 16'(tracks),
                    16'($urandom_range(0, 65535)));
        repeat (tracks)
        begin
            push_track_head();
            repeat (events)
                push_event(noisy);
            push_vlq(rand_delta());
            push(8'hFF); push(mfep_pkg::META_EOT); push(8'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_all(bit gaps);
        while (file_bytes.size() > 0)
            send_byte(file_bytes.pop_front(), file_first.pop_front(), gaps);
    endtask

    task automatic wait_drained();
        while (board.pending.size() > 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off when asked.
    initial
    begin
        int g;
        g = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else if (g > 0)
            begin
                m_tready <= 1'b0;
                g--;
            end
            else
            begin
                m_tready <= 1'b1;
                g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            end
        end
    end

    // Check every accepted result word.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_word(mfep_pkg::result_t'(m_tdata[mfep_pkg::RES_W-1:0]), m_tlast);

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("tb_midi_file_event_parser NOT OK");
            $finish;
        end
    end

    initial
    begin
        board = new();
        board.restart();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: minimal files, zero tracks, maximal deltas, errors.
        push_header(8'hFF, 16'd0, 16'hFFFF);
        push_header(8'h00, 16'd1, 16'h0000);
        push_track_head();
        push_vlq(28'hFFF_FFFF); push(8'h90); push(8'h7F); push(8'h00);
        push_vlq(28'hFFF_FFFF); push(8'hC5); push(8'h10);
        push_vlq(28'hFFF_FFFF); push(8'hFF); push(mfep_pkg::META_EOT); push(8'd0);
        send_all(1'b1);
        push("X"); file_first[0] = 1'b1; push("M");
        push_header(8'd1, 16'd1, 16'd96); push("M"); push("T"); push("r"); push("x");
        push_header(8'd1, 16'd1, 16'd96); push_track_head();
        push(8'd0); push(8'hFF); push(mfep_pkg::META_TEMPO);
        push(8'h82); push(8'h80); push(8'h80);
        send_all(1'b0);
        wait_drained();

        // Receiver hold-off while a whole file is sent, so the sender stalls.
        push_file(1, 8, 1'b0);
        hold_off = 1'b1;
        fork
            send_all(1'b0);
            begin
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
        join
        s_tvalid <= 1'b0;
        wait_drained();

        // Random files, mostly well formed.
        while (byte_total < 220)
        begin
            push_file($urandom_range(1, 2), $urandom_range(1, 6),
                      $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                push(8'($urandom_range(0, 255)));
            send_all(1'b1);
        end
        s_tvalid <= 1'b0;
        s_tuser <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb_midi_file_event_parser OK");
        else
            $display("tb_midi_file_event_parser NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
design/mfep_pkg.sv
design/mfep_core.sv
design/mfep_out_queue.sv
design/midi_file_event_parser.sv
dv/tb_midi_file_event_parser.sv
